/* rtl/rti_pkg.sv */
// Shared types and widths for the ray/triangle intersection pipeline.
// No dependencies; every rtl module imports this package.
package rti_pkg;

  localparam int CW    = 21;            // coordinate width, signed fixed point
  localparam int EW    = CW + 1;        // edge / difference width
  localparam int NW    = 2 * EW + 1;    // normal component width
  localparam int NLO   = NW - EW;       // low slice of a normal component
  localparam int PW    = NW + EW;       // normal times difference
  localparam int SW    = PW + 2;        // sum of three such products
  localparam int DW    = SW;            // magnitude of numerator / denominator
  localparam int AW    = 2 * EW + 1;    // projected area width
  localparam int GW    = AW + 2;        // third barycentric numerator
  localparam int TW    = 32;            // distance width
  localparam int TF    = 16;            // distance fraction bits
  localparam int COLW  = 24;
  localparam int SETTLE = 4;            // busy counter reload value while derived geometry refreshes

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [1:0] {
    REG_VERTEX_A = 2'd0,
    REG_VERTEX_B = 2'd1,
    REG_VERTEX_C = 2'd2,
    REG_COLOR    = 2'd3
  } reg_addr_t;

  typedef struct packed {
    coord_t [2:0] o;
    coord_t [2:0] d;
  } ray_t;

  // Geometry derived from the vertex registers
  typedef struct packed {
    coord_t [2:0]          a;
    coord_t [2:0]          b;
    coord_t [2:0]          c;
    logic [2:0][NW-1:0]    n;
    logic [EW-1:0]         bc0;
    logic [EW-1:0]         bc1;
    logic [EW-1:0]         ab0;
    logic [EW-1:0]         ab1;
    logic [AW-1:0]         bd;
    logic [COLW-1:0]       color;
  } geo_t;

  typedef struct packed {
    ray_t          ray;
    logic          miss;
    logic          sat;
    logic [DW-1:0] rem;
    logic [DW-1:0] den;
    logic [TF-1:0] low;
    logic [TW-1:0] q;
  } div_t;

  typedef struct packed {
    ray_t          ray;
    logic          miss;
    logic [TW-1:0] t;
  } mid_t;

endpackage

/* rtl/rti_setup.sv */
// Configuration registers on the APB port and the triangle geometry derived from them.
// Depends on rti_pkg.
module rti_setup (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output rti_pkg::geo_t      geo,
  output logic               busy
);
  import rti_pkg::*;

  logic [62:0]     va, vb, vc;
  logic [COLW-1:0] color;
  logic [2:0]      settle;
  logic            wr;
  reg_addr_t       addr;

  coord_t ca [3];
  coord_t cb [3];
  coord_t cc [3];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [EW-1:0] bc0, bc1, ab0, ab1, ac0, ac1;
  logic signed [2*EW-1:0] pm [8];
  logic signed [NW-1:0] n [3];
  logic signed [AW-1:0] bd;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign addr   = reg_addr_t'(paddr[4:3]);
  assign busy   = settle != 3'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      va     <= '0;
      vb     <= '0;
      vc     <= '0;
      color  <= '0;
      settle <= 3'(SETTLE);
    end else begin
      if (wr) begin
        settle <= 3'(SETTLE);
        case (addr)
          REG_VERTEX_A: va    <= pwdata[62:0];
          REG_VERTEX_B: vb    <= pwdata[62:0];
          REG_VERTEX_C: vc    <= pwdata[62:0];
          REG_COLOR:    color <= pwdata[COLW-1:0];
          default:      ;
        endcase
      end else if (settle != 3'd0) begin
        settle <= settle - 3'd1;
      end
    end
  end

  always_comb begin
    case (addr)
      REG_VERTEX_A: prdata = {1'b0, va};
      REG_VERTEX_B: prdata = {1'b0, vb};
      REG_VERTEX_C: prdata = {1'b0, vc};
      REG_COLOR:    prdata = 64'(color);
      default:      prdata = '0;
    endcase
  end

  // Unpack, difference, multiply, combine
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ca[k] <= va[k*CW +: CW];
      cb[k] <= vb[k*CW +: CW];
      cc[k] <= vc[k*CW +: CW];
      e1[k] <= EW'(cb[k]) - EW'(ca[k]);
      e2[k] <= EW'(cc[k]) - EW'(ca[k]);
    end
    bc0 <= EW'(cb[0]) - EW'(cc[0]);
    bc1 <= EW'(cb[1]) - EW'(cc[1]);
    ab0 <= EW'(ca[0]) - EW'(cb[0]);
    ab1 <= EW'(ca[1]) - EW'(cb[1]);
    ac0 <= EW'(ca[0]) - EW'(cc[0]);
    ac1 <= EW'(ca[1]) - EW'(cc[1]);
    pm[0] <= e1[1] * e2[2];
    pm[1] <= e1[2] * e2[1];
    pm[2] <= e1[2] * e2[0];
    pm[3] <= e1[0] * e2[2];
    pm[4] <= e1[0] * e2[1];
    pm[5] <= e1[1] * e2[0];
    pm[6] <= ac1 * bc0;
    pm[7] <= ac0 * bc1;
    for (int k = 0; k < 3; k++) begin
      n[k] <= NW'(pm[2*k]) - NW'(pm[2*k+1]);
    end
    bd <= AW'(pm[6]) - AW'(pm[7]);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      geo.a[k] = ca[k];
      geo.b[k] = cb[k];
      geo.c[k] = cc[k];
      geo.n[k] = n[k];
    end
    geo.bc0   = bc0;
    geo.bc1   = bc1;
    geo.ab0   = ab0;
    geo.ab1   = ab1;
    geo.bd    = bd;
    geo.color = color;
  end

endmodule

/* rtl/rti_plane.sv */
// Plane stages: n.d and n.(a-o), sign normalization and divider setup.
// Depends on rti_pkg.
module rti_plane (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  rti_pkg::ray_t   in_ray,
  input  rti_pkg::geo_t   geo,
  output logic            out_valid,
  output rti_pkg::div_t   out_div
);
  import rti_pkg::*;

  logic [6:0] v;
  ray_t r1, r2, r3, r4, r5, r6;
  logic signed [EW-1:0] am [3];
  logic signed [NLO+EW:0] pdl [3];
  logic signed [NLO+EW:0] pml [3];
  logic signed [2*EW-1:0] pdh [3];
  logic signed [2*EW-1:0] pmh [3];
  logic signed [PW-1:0] pd [3];
  logic signed [PW-1:0] pn [3];
  logic signed [SW-1:0] den, num;
  logic signed [SW-1:0] dn, nn;
  logic [DW-1:0] dabs, nabs;
  logic dz, nneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:0], in_valid};
    end
  end

  always_comb begin
    dn = den[SW-1] ? -den : den;
    nn = den[SW-1] ? -num : num;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1 <= in_ray;
      r2 <= r1;
      for (int k = 0; k < 3; k++) begin
        am[k] <= EW'($signed(geo.a[k])) - EW'($signed(r1.o[k]));
      end
      r3 <= r2;
      for (int k = 0; k < 3; k++) begin
        // split each normal component: unsigned low slice, signed high slice
        pdl[k] <= $signed({1'b0, geo.n[k][NLO-1:0]}) * EW'($signed(r2.d[k]));
        pml[k] <= $signed({1'b0, geo.n[k][NLO-1:0]}) * am[k];
        pdh[k] <= $signed(geo.n[k][NW-1:NLO]) * EW'($signed(r2.d[k]));
        pmh[k] <= $signed(geo.n[k][NW-1:NLO]) * am[k];
      end
      r4 <= r3;
      for (int k = 0; k < 3; k++) begin
        pd[k] <= (PW'(pdh[k]) <<< NLO) + PW'(pdl[k]);
        pn[k] <= (PW'(pmh[k]) <<< NLO) + PW'(pml[k]);
      end
      r5 <= r4;
      den <= SW'(pd[0]) + SW'(pd[1]) + SW'(pd[2]);
      num <= SW'(pn[0]) + SW'(pn[1]) + SW'(pn[2]);
      r6 <= r5;
      dz   <= den == '0;
      nneg <= nn[SW-1];
      dabs <= DW'(dn);
      nabs <= DW'(nn);
      out_div.ray  <= r6;
      out_div.miss <= dz || nneg;
      // quotient would not fit in 32 bits
      out_div.sat  <= (DW+TF)'(nabs) >= ((DW+TF)'(dabs) << TF);
      out_div.rem  <= nabs >> TF;
      out_div.den  <= dabs;
      out_div.low  <= nabs[TF-1:0];
      out_div.q    <= '0;
    end
  end

  assign out_valid = v[6];

endmodule

/* rtl/rti_div.sv */
// Pipelined restoring divider: one quotient bit per stage, 32 stages.
// Depends on rti_pkg.
module rti_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  rti_pkg::div_t   in_div,
  output logic            out_valid,
  output rti_pkg::mid_t   out_mid
);
  import rti_pkg::*;

  div_t st [TW+1];
  logic [TW:0] v;

  assign st[0] = in_div;
  assign v[0]  = in_valid;

  for (genvar i = 0; i < TW; i++) begin : g_stage
    logic [DW:0] r2;
    logic        ge;
    div_t        nx;

    assign r2 = {st[i].rem, st[i].low[TF-1]};
    assign ge = r2 >= {1'b0, st[i].den};

    always_comb begin
      nx     = st[i];
      nx.rem = DW'(ge ? r2 - {1'b0, st[i].den} : r2);
      nx.low = st[i].low << 1;
      nx.q   = {st[i].q[TW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1] <= nx;
      end
    end
  end

  assign out_valid    = v[TW];
  assign out_mid.ray  = st[TW].ray;
  assign out_mid.miss = st[TW].miss;
  assign out_mid.t    = st[TW].sat ? '1 : st[TW].q;

endmodule

/* rtl/rti_hit.sv */
// Hit point, projected barycentric test and the output register.
// Depends on rti_pkg.
module rti_hit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  rti_pkg::mid_t         in_mid,
  input  rti_pkg::geo_t         geo,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic [rti_pkg::TW-1:0] out_t,
  output rti_pkg::coord_t [2:0] out_p,
  output logic [rti_pkg::COLW-1:0] out_color
);
  import rti_pkg::*;

  localparam int MW = TW + 1 + CW;
  localparam int SUMW = MW + 1;

  logic [3:0] v;
  logic [3:0] miss;
  logic [TW-1:0] t1, t2, t3, t4;
  coord_t o1 [3];
  logic signed [MW-1:0] prod [3];
  coord_t p2 [3];
  coord_t p3 [3];
  coord_t p4 [3];
  logic signed [SUMW-1:0] sum [3];
  coord_t psat [3];
  logic signed [2*EW-1:0] bp [4];
  logic signed [AW-1:0] an, bn;
  logic signed [GW-1:0] gn;
  logic opp_a, opp_b, opp_g, sd0;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = SUMW'(prod[k] >>> TF) + SUMW'(o1[k]);
      if (sum[k][SUMW-1:CW-1] == '0 || sum[k][SUMW-1:CW-1] == '1) begin
        psat[k] = sum[k][CW-1:0];
      end else if (sum[k][SUMW-1]) begin
        psat[k] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        psat[k] = {1'b0, {(CW-1){1'b1}}};
      end
    end
    sd0   = geo.bd == '0;
    // a nonzero numerator of opposite sign to the area puts the point outside
    opp_a = an != '0 && (an[AW-1] != geo.bd[AW-1]);
    opp_b = bn != '0 && (bn[AW-1] != geo.bd[AW-1]);
    opp_g = gn != '0 && (gn[GW-1] != geo.bd[AW-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[2:0], in_valid};
      out_valid <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      miss[0] <= in_mid.miss;
      t1      <= in_mid.t;
      for (int k = 0; k < 3; k++) begin
        o1[k]   <= in_mid.ray.o[k];
        prod[k] <= $signed({1'b0, in_mid.t}) * $signed(in_mid.ray.d[k]);
      end
      miss[1] <= miss[0];
      t2      <= t1;
      for (int k = 0; k < 3; k++) begin
        p2[k] <= psat[k];
      end
      miss[2] <= miss[1];
      t3      <= t2;
      p3      <= p2;
      bp[0] <= (EW'(p2[1]) - EW'($signed(geo.c[1]))) * $signed(geo.bc0);
      bp[1] <= (EW'(p2[0]) - EW'($signed(geo.c[0]))) * $signed(geo.bc1);
      bp[2] <= (EW'(p2[1]) - EW'($signed(geo.b[1]))) * $signed(geo.ab0);
      bp[3] <= (EW'(p2[0]) - EW'($signed(geo.b[0]))) * $signed(geo.ab1);
      miss[3] <= miss[2];
      t4      <= t3;
      p4      <= p3;
      an <= AW'(bp[0]) - AW'(bp[1]);
      bn <= AW'(bp[2]) - AW'(bp[3]);
      gn <= GW'($signed(geo.bd)) - GW'(bp[0]) + GW'(bp[1]) - GW'(bp[2]) + GW'(bp[3]);
      if (miss[3] || sd0 || opp_a || opp_b || opp_g) begin
        out_hit   <= 1'b0;
        out_t     <= '0;
        out_p     <= '0;
        out_color <= '0;
      end else begin
        out_hit   <= 1'b1;
        out_t     <= t4;
        for (int k = 0; k < 3; k++) begin
          out_p[k] <= p4[k];
        end
        out_color <= geo.color;
      end
    end
  end

endmodule

/* rtl/ray_triangle_intersect.sv */
// Ray / triangle intersection engine, one ray per clock unless stalled or refreshing geometry.
// Rays enter on the s_axis stream: origin and direction, signed Q10.10.
// The triangle's three vertices and its color are APB registers at byte
// addresses 0, 8, 16 and 24 (64-bit data); write them only while no ray
// is in flight. After each register write, and after reset, s_axis_tready
// stays low while the plane normal and projected area refresh.
// Each accepted ray gives exactly one transfer on m_axis: tuser holds the
// hit flag, tdata the distance t (unsigned Q16.16, saturating), the hit
// point and the color; a miss sends all zeros.
// The pipeline has 7 plane stages, a 32-stage divider that resolves one
// quotient bit per stage, and 5 stages for the hit point and barycentric
// test. Throughput is one ray per cycle unless stalled or refreshing geometry.
// The whole pipeline advances only when the output register is empty or
// being taken; a stalled receiver freezes every stage, nothing is dropped.
// Synchronous reset empties the pipeline and clears the APB registers.
// Depends on rti_pkg, rti_setup, rti_plane, rti_div, rti_hit.
module ray_triangle_intersect (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (21 bits each), 2 pad
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // distance_t (32), point_x, point_y, point_z (21 each), hit_color (24), 1 pad
  output logic [119:0] m_axis_tdata,
  // hit
  output logic [0:0]   m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import rti_pkg::*;

  geo_t   geo;
  logic   busy;
  logic   en;
  ray_t   in_ray;
  logic   pl_valid;
  div_t   pl_div;
  logic   dv_valid;
  mid_t   dv_mid;
  logic   hit;
  logic [TW-1:0] t;
  coord_t [2:0]  p;
  logic [COLW-1:0] color;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !busy;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_ray.o[k] = s_axis_tdata[k*CW +: CW];
      in_ray.d[k] = s_axis_tdata[(k+3)*CW +: CW];
    end
  end

  rti_setup u_setup (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .geo, .busy
  );

  rti_plane u_plane (
    .clk, .rst, .en,
    .in_valid (s_axis_tvalid && s_axis_tready),
    .in_ray,
    .geo,
    .out_valid (pl_valid),
    .out_div   (pl_div)
  );

  rti_div u_div (
    .clk, .rst, .en,
    .in_valid  (pl_valid),
    .in_div    (pl_div),
    .out_valid (dv_valid),
    .out_mid   (dv_mid)
  );

  rti_hit u_hit (
    .clk, .rst, .en,
    .in_valid  (dv_valid),
    .in_mid    (dv_mid),
    .geo,
    .out_valid (m_axis_tvalid),
    .out_hit   (hit),
    .out_t     (t),
    .out_p     (p),
    .out_color (color)
  );

  assign m_axis_tuser = hit;
  assign m_axis_tdata = {1'b0, color, p[2], p[1], p[0], t};

  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tdata == '0)
    else $error("miss result carries nonzero data");

  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tdata[118:95] == geo.color)
    else $error("hit color differs from surface color");

  assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule
